### rtl/core/pta_pkg.sv
package pta_pkg;

    localparam int MAX_TEXTURE_SIDE_DEF = 1024;
    localparam int COORD_BITS_DEF       = 12;
    localparam int UV_FRAC_BITS_DEF     = 16;

    // Perspective w is unsigned Q12.12.
    localparam int W_BITS = 24;

    localparam int SLOT_BITS = 2;
    localparam int NUM_SLOTS = 3;

    // Register stages inside the weight accumulator.
    localparam int WEIGHT_STAGES = 6;

    localparam int TEX_COLS_RESET = 64;
    localparam int TEX_ROWS_RESET = 64;

    typedef enum logic {
        FUNC_LOAD  = 1'b0,
        FUNC_PIXEL = 1'b1
    } func_t;

    typedef enum logic {
        REG_TEX_COLS = 1'b0,
        REG_TEX_ROWS = 1'b1
    } cfg_reg_t;

endpackage

### rtl/core/pta_setup.sv
module pta_setup import pta_pkg::*; #(
    parameter int COORD_BITS   = COORD_BITS_DEF,
    parameter int UV_FRAC_BITS = UV_FRAC_BITS_DEF,
    parameter int SIDE_BITS    = 11,
    localparam int DW          = COORD_BITS + 1,
    localparam int PW          = 2 * DW,
    localparam int NW          = PW + 3,
    localparam int UW          = UV_FRAC_BITS + SIDE_BITS,
    localparam int PB          = 2 * W_BITS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           adv,
    input  logic                           in_valid,
    input  logic signed [COORD_BITS-1:0]   px,
    input  logic signed [COORD_BITS-1:0]   py,
    input  logic signed [COORD_BITS-1:0]   vx [NUM_SLOTS],
    input  logic signed [COORD_BITS-1:0]   vy [NUM_SLOTS],
    input  logic        [W_BITS-1:0]       vw [NUM_SLOTS],
    input  logic        [UV_FRAC_BITS-1:0] vu [NUM_SLOTS],
    input  logic        [UV_FRAC_BITS-1:0] vv [NUM_SLOTS],
    input  logic        [SIDE_BITS-1:0]    cols,
    input  logic        [SIDE_BITS-1:0]    rows,
    output logic                           out_valid,
    output logic signed [COORD_BITS-1:0]   px_out,
    output logic signed [COORD_BITS-1:0]   py_out,
    output logic signed [NW-1:0]           n_out [NUM_SLOTS],
    output logic        [PB-1:0]           p_out [NUM_SLOTS],
    output logic        [UW-1:0]           uc_out [NUM_SLOTS],
    output logic        [UW-1:0]           vr_out [NUM_SLOTS],
    output logic                           degen_out
);

    logic va_reg, vb_reg, vc_reg;

    logic signed [COORD_BITS-1:0] px_a_reg, py_a_reg, px_b_reg, py_b_reg, px_c_reg, py_c_reg;
    logic signed [DW-1:0] e20x_next, e10y_next, e20y_next, e10x_next;
    logic signed [DW-1:0] qx2_next, qy1_next, qy2_next, qx1_next, qy0_next, qx0_next;
    logic signed [DW-1:0] e20x_reg, e10y_reg, e20y_reg, e10x_reg;
    logic signed [DW-1:0] qx2_reg, qy1_reg, qy2_reg, qx1_reg, qy0_reg, qx0_reg;
    logic        [PB-1:0] p_next [NUM_SLOTS];
    logic        [UW-1:0] uc_next [NUM_SLOTS];
    logic        [UW-1:0] vr_next [NUM_SLOTS];
    logic        [PB-1:0] p_a_reg [NUM_SLOTS];
    logic        [PB-1:0] p_b_reg [NUM_SLOTS];
    logic        [PB-1:0] p_c_reg [NUM_SLOTS];
    logic        [UW-1:0] uc_a_reg [NUM_SLOTS];
    logic        [UW-1:0] uc_b_reg [NUM_SLOTS];
    logic        [UW-1:0] uc_c_reg [NUM_SLOTS];
    logic        [UW-1:0] vr_a_reg [NUM_SLOTS];
    logic        [UW-1:0] vr_b_reg [NUM_SLOTS];
    logic        [UW-1:0] vr_c_reg [NUM_SLOTS];

    logic signed [PW-1:0] pr_next [6];
    logic signed [PW-1:0] pr_reg [6];

    logic signed [NW-1:0] area_c, na_c, nb_c, nc_c;
    logic signed [NW-1:0] n_next [NUM_SLOTS];
    logic signed [NW-1:0] n_reg [NUM_SLOTS];
    logic                 degen_reg;

    always_comb begin
        e20x_next = DW'(vx[2]) - DW'(vx[0]);
        e10y_next = DW'(vy[1]) - DW'(vy[0]);
        e20y_next = DW'(vy[2]) - DW'(vy[0]);
        e10x_next = DW'(vx[1]) - DW'(vx[0]);
        qx2_next  = DW'(vx[2]) - DW'(px);
        qy1_next  = DW'(vy[1]) - DW'(py);
        qy2_next  = DW'(vy[2]) - DW'(py);
        qx1_next  = DW'(vx[1]) - DW'(px);
        qy0_next  = DW'(py) - DW'(vy[0]);
        qx0_next  = DW'(px) - DW'(vx[0]);
        p_next[0] = PB'(vw[1]) * PB'(vw[2]);
        p_next[1] = PB'(vw[0]) * PB'(vw[2]);
        p_next[2] = PB'(vw[0]) * PB'(vw[1]);
        for (int i = 0; i < NUM_SLOTS; i++) begin
            uc_next[i] = UW'(vu[i]) * UW'(cols);
            vr_next[i] = UW'(vv[i]) * UW'(rows);
        end
    end

    always_comb begin
        pr_next[0] = e20x_reg * e10y_reg;
        pr_next[1] = e20y_reg * e10x_reg;
        pr_next[2] = qx2_reg * qy1_reg;
        pr_next[3] = qy2_reg * qx1_reg;
        pr_next[4] = e20x_reg * qy0_reg;
        pr_next[5] = e20y_reg * qx0_reg;
    end

    always_comb begin
        area_c    = NW'(pr_reg[0]) - NW'(pr_reg[1]);
        na_c      = NW'(pr_reg[2]) - NW'(pr_reg[3]);
        nb_c      = NW'(pr_reg[4]) - NW'(pr_reg[5]);
        nc_c      = area_c - na_c - nb_c;
        n_next[0] = na_c;
        n_next[1] = nb_c;
        n_next[2] = nc_c;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end else if (adv) begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            px_a_reg <= px;
            py_a_reg <= py;
            e20x_reg <= e20x_next;
            e10y_reg <= e10y_next;
            e20y_reg <= e20y_next;
            e10x_reg <= e10x_next;
            qx2_reg  <= qx2_next;
            qy1_reg  <= qy1_next;
            qy2_reg  <= qy2_next;
            qx1_reg  <= qx1_next;
            qy0_reg  <= qy0_next;
            qx0_reg  <= qx0_next;
            px_b_reg <= px_a_reg;
            py_b_reg <= py_a_reg;
            pr_reg   <= pr_next;
            px_c_reg <= px_b_reg;
            py_c_reg <= py_b_reg;
            n_reg    <= n_next;
            degen_reg <= (area_c == '0);
            p_a_reg  <= p_next;
            p_b_reg  <= p_a_reg;
            p_c_reg  <= p_b_reg;
            uc_a_reg <= uc_next;
            uc_b_reg <= uc_a_reg;
            uc_c_reg <= uc_b_reg;
            vr_a_reg <= vr_next;
            vr_b_reg <= vr_a_reg;
            vr_c_reg <= vr_b_reg;
        end
    end

    assign out_valid = vc_reg;
    assign px_out    = px_c_reg;
    assign py_out    = py_c_reg;
    assign n_out     = n_reg;
    assign p_out     = p_c_reg;
    assign uc_out    = uc_c_reg;
    assign vr_out    = vr_c_reg;
    assign degen_out = degen_reg;

endmodule

### rtl/core/pta_weight.sv
module pta_weight import pta_pkg::*; #(
    parameter int COORD_BITS   = COORD_BITS_DEF,
    parameter int UV_FRAC_BITS = UV_FRAC_BITS_DEF,
    parameter int SIDE_BITS    = 11,
    localparam int NW          = 2 * (COORD_BITS + 1) + 3,
    localparam int UW          = UV_FRAC_BITS + SIDE_BITS,
    localparam int PB          = 2 * W_BITS,
    localparam int NPW         = NW + PB,
    localparam int TMW         = NPW + UW,
    localparam int NUW         = TMW + 2,
    localparam int DENW        = NPW + 2
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 adv,
    input  logic                 in_valid,
    input  logic signed [NW-1:0] n_in [NUM_SLOTS],
    input  logic        [PB-1:0] p_in [NUM_SLOTS],
    input  logic        [UW-1:0] uc_in [NUM_SLOTS],
    input  logic        [UW-1:0] vr_in [NUM_SLOTS],
    input  logic                 kill_in,
    output logic                 out_valid,
    output logic [NUW-1:0]       num_u,
    output logic [NUW-1:0]       num_v,
    output logic [DENW-1:0]      den,
    output logic                 kill_out
);

    localparam int LW  = NW + W_BITS + 1;
    localparam int CH  = (NPW + 2) / 3;
    localparam int PRW = CH + UW + 2;

    logic v_reg [WEIGHT_STAGES];
    logic k_reg [WEIGHT_STAGES];

    logic signed [LW-1:0]  lo_next [NUM_SLOTS];
    logic signed [LW-1:0]  hi_next [NUM_SLOTS];
    logic signed [LW-1:0]  lo_reg [NUM_SLOTS];
    logic signed [LW-1:0]  hi_reg [NUM_SLOTS];
    logic        [UW-1:0]  uc_d_reg [NUM_SLOTS];
    logic        [UW-1:0]  vr_d_reg [NUM_SLOTS];
    logic        [UW-1:0]  uc_e_reg [NUM_SLOTS];
    logic        [UW-1:0]  vr_e_reg [NUM_SLOTS];

    logic signed [NPW-1:0] np_next [NUM_SLOTS];
    logic signed [NPW-1:0] np_reg [NUM_SLOTS];

    logic signed [DENW-1:0] den_next, den_f_reg;
    logic signed [PRW-1:0]  pu_next [NUM_SLOTS][3];
    logic signed [PRW-1:0]  pv_next [NUM_SLOTS][3];
    logic signed [PRW-1:0]  pu_reg [NUM_SLOTS][3];
    logic signed [PRW-1:0]  pv_reg [NUM_SLOTS][3];

    logic signed [TMW-1:0]  tu_next [NUM_SLOTS];
    logic signed [TMW-1:0]  tv_next [NUM_SLOTS];
    logic signed [TMW-1:0]  tu_reg [NUM_SLOTS];
    logic signed [TMW-1:0]  tv_reg [NUM_SLOTS];
    logic        [DENW-1:0] dabs_next, dabs_g_reg, dabs_h_reg, dabs_i_reg;
    logic                   dzero;

    logic signed [NUW-1:0]  su_next, sv_next, su_reg, sv_reg;
    logic        [NUW-1:0]  au_reg, av_reg;

    always_comb begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            lo_next[i] = LW'(n_in[i]) * LW'($signed({1'b0, p_in[i][W_BITS-1:0]}));
            hi_next[i] = LW'(n_in[i]) * LW'($signed({1'b0, p_in[i][PB-1:W_BITS]}));
            np_next[i] = (NPW'(hi_reg[i]) <<< W_BITS) + NPW'(lo_reg[i]);
        end
    end

    always_comb begin
        den_next = DENW'(np_reg[0]) + DENW'(np_reg[1]) + DENW'(np_reg[2]);
        for (int i = 0; i < NUM_SLOTS; i++) begin
            pu_next[i][0] = PRW'($signed({1'b0, np_reg[i][CH-1:0]}))
                          * PRW'($signed({1'b0, uc_e_reg[i]}));
            pu_next[i][1] = PRW'($signed({1'b0, np_reg[i][2*CH-1:CH]}))
                          * PRW'($signed({1'b0, uc_e_reg[i]}));
            pu_next[i][2] = PRW'($signed(np_reg[i][NPW-1:2*CH]))
                          * PRW'($signed({1'b0, uc_e_reg[i]}));
            pv_next[i][0] = PRW'($signed({1'b0, np_reg[i][CH-1:0]}))
                          * PRW'($signed({1'b0, vr_e_reg[i]}));
            pv_next[i][1] = PRW'($signed({1'b0, np_reg[i][2*CH-1:CH]}))
                          * PRW'($signed({1'b0, vr_e_reg[i]}));
            pv_next[i][2] = PRW'($signed(np_reg[i][NPW-1:2*CH]))
                          * PRW'($signed({1'b0, vr_e_reg[i]}));
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            tu_next[i] = (TMW'(pu_reg[i][2]) <<< (2 * CH)) + (TMW'(pu_reg[i][1]) <<< CH)
                       + TMW'(pu_reg[i][0]);
            tv_next[i] = (TMW'(pv_reg[i][2]) <<< (2 * CH)) + (TMW'(pv_reg[i][1]) <<< CH)
                       + TMW'(pv_reg[i][0]);
        end
        dabs_next = den_f_reg[DENW-1] ? DENW'(-den_f_reg) : DENW'(den_f_reg);
        dzero     = (den_f_reg == '0);
        su_next   = NUW'(tu_reg[0]) + NUW'(tu_reg[1]) + NUW'(tu_reg[2]);
        sv_next   = NUW'(tv_reg[0]) + NUW'(tv_reg[1]) + NUW'(tv_reg[2]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < WEIGHT_STAGES; s++) begin
                v_reg[s] <= 1'b0;
            end
        end else if (adv) begin
            v_reg[0] <= in_valid;
            for (int s = 1; s < WEIGHT_STAGES; s++) begin
                v_reg[s] <= v_reg[s-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            k_reg[0] <= kill_in;
            k_reg[1] <= k_reg[0];
            k_reg[2] <= k_reg[1];
            k_reg[3] <= k_reg[2] | dzero;
            k_reg[4] <= k_reg[3];
            k_reg[5] <= k_reg[4];
            lo_reg     <= lo_next;
            hi_reg     <= hi_next;
            uc_d_reg   <= uc_in;
            vr_d_reg   <= vr_in;
            np_reg     <= np_next;
            uc_e_reg   <= uc_d_reg;
            vr_e_reg   <= vr_d_reg;
            den_f_reg  <= den_next;
            pu_reg     <= pu_next;
            pv_reg     <= pv_next;
            tu_reg     <= tu_next;
            tv_reg     <= tv_next;
            dabs_g_reg <= dabs_next;
            su_reg     <= su_next;
            sv_reg     <= sv_next;
            dabs_h_reg <= dabs_g_reg;
            au_reg     <= su_reg[NUW-1] ? NUW'(-su_reg) : NUW'(su_reg);
            av_reg     <= sv_reg[NUW-1] ? NUW'(-sv_reg) : NUW'(sv_reg);
            dabs_i_reg <= dabs_h_reg;
        end
    end

    assign out_valid = v_reg[WEIGHT_STAGES-1];
    assign kill_out  = k_reg[WEIGHT_STAGES-1];
    assign num_u     = au_reg;
    assign num_v     = av_reg;
    assign den       = dabs_i_reg;

endmodule

### rtl/core/pta_divide.sv
module pta_divide import pta_pkg::*; #(
    parameter int NUM_W    = 108,
    parameter int DEN_W    = 79,
    parameter int FRAC     = UV_FRAC_BITS_DEF,
    parameter int TEX_BITS = 10,
    localparam int QW      = TEX_BITS + 1,
    localparam int DDW     = DEN_W + FRAC,
    localparam int RW      = (NUM_W > DDW + QW) ? NUM_W : DDW + QW
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                adv,
    input  logic                in_valid,
    input  logic [NUM_W-1:0]    num,
    input  logic [DEN_W-1:0]    den,
    input  logic                kill,
    input  logic [TEX_BITS-1:0] lim,
    output logic                out_valid,
    output logic [TEX_BITS-1:0] quo
);

    logic              v_reg [QW];
    logic              k_reg [QW];
    logic [QW-1:0]     q_reg [QW];
    logic [RW-1:0]     rem_reg [QW-1];
    logic [DDW-1:0]    dd_reg [QW-1];

    logic                out_v_reg;
    logic [TEX_BITS-1:0] quo_reg;
    logic [QW-1:0]       q_last;

    for (genvar s = 0; s < QW; s++) begin : g_bit
        localparam int K = QW - 1 - s;
        logic [RW-1:0]  rem_in, trial;
        logic [DDW-1:0] d_in;
        logic [QW-1:0]  q_in;
        logic           v_in, k_in, take;

        if (s == 0) begin : g_first
            assign rem_in = RW'(num);
            assign d_in   = {den, {FRAC{1'b0}}};
            assign q_in   = '0;
            assign v_in   = in_valid;
            assign k_in   = kill;
        end else begin : g_rest
            assign rem_in = rem_reg[s-1];
            assign d_in   = dd_reg[s-1];
            assign q_in   = q_reg[s-1];
            assign v_in   = v_reg[s-1];
            assign k_in   = k_reg[s-1];
        end

        assign trial = RW'(d_in) << K;
        assign take  = (rem_in >= trial);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[s] <= 1'b0;
            end else if (adv) begin
                v_reg[s] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                k_reg[s] <= k_in;
                q_reg[s] <= take ? (q_in | (QW'(1) << K)) : q_in;
            end
        end

        if (s < QW - 1) begin : g_keep
            always_ff @(posedge aclk) begin
                if (adv) begin
                    dd_reg[s]  <= d_in;
                    rem_reg[s] <= take ? (rem_in - trial) : rem_in;
                end
            end
        end
    end

    assign q_last = q_reg[QW-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (adv) begin
            out_v_reg <= v_reg[QW-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (k_reg[QW-1]) begin
                quo_reg <= '0;
            end else if (q_last > QW'(lim)) begin
                quo_reg <= lim;
            end else begin
                quo_reg <= q_last[TEX_BITS-1:0];
            end
        end
    end

    assign out_valid = out_v_reg;
    assign quo       = quo_reg;

endmodule

### rtl/core/perspective_texel_address.sv
// Channel  | Ports                                   | Moves
// ---------+-----------------------------------------+----------------------------------
// input    | s_valid, s_ready, s_func ... s_tex_v     | vertex loads and pixel words
// result   | m_valid, m_ready, m_pixel_x ... m_degenerate | one texel address word per pixel
// config   | cfg_wr_en, cfg_idx, cfg_wdata            | texture width and height writes
//
// One word is accepted per clock while the skid buffer is empty. A pixel
// word passes the setup, weight and divider stages and the output registers
// in that order; the divider resolves one quotient bit per stage.
// Vertex loads take effect at once and produce no result word.
// Reset clears the pipeline valid bits and sets the texture size registers to TEX_COLS_RESET and TEX_ROWS_RESET.
// A stalled result is held in a one-word skid buffer, and the pipeline
// freezes while that buffer is full.
module perspective_texel_address import pta_pkg::*; #(
    parameter int MAX_TEXTURE_SIDE = MAX_TEXTURE_SIDE_DEF,
    parameter int COORD_BITS       = COORD_BITS_DEF,
    parameter int UV_FRAC_BITS     = UV_FRAC_BITS_DEF,
    localparam int TEX_BITS        = $clog2(MAX_TEXTURE_SIDE),
    localparam int SIDE_BITS       = $clog2(MAX_TEXTURE_SIDE + 1),
    localparam int INDEX_BITS      = 2 * TEX_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_func,
    input  logic [SLOT_BITS-1:0]          s_vertex_slot,
    input  logic signed [COORD_BITS-1:0]  s_pos_x,
    input  logic signed [COORD_BITS-1:0]  s_pos_y,
    input  logic [W_BITS-1:0]             s_depth_w,
    input  logic [UV_FRAC_BITS-1:0]       s_tex_u,
    input  logic [UV_FRAC_BITS-1:0]       s_tex_v,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [COORD_BITS-1:0]  m_pixel_x,
    output logic signed [COORD_BITS-1:0]  m_pixel_y,
    output logic [TEX_BITS-1:0]           m_texel_col,
    output logic [TEX_BITS-1:0]           m_texel_row,
    output logic [INDEX_BITS-1:0]         m_texel_index,
    output logic                          m_degenerate,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_idx,
    input  logic [SIDE_BITS-1:0]          cfg_wdata
);

    localparam int NW         = 2 * (COORD_BITS + 1) + 3;
    localparam int UW         = UV_FRAC_BITS + SIDE_BITS;
    localparam int PB         = 2 * W_BITS;
    localparam int NPW        = NW + PB;
    localparam int NUW        = NPW + UW + 2;
    localparam int DENW       = NPW + 2;
    localparam int SIDE_W     = 2 * COORD_BITS + 1;
    localparam int LINE_DEPTH = WEIGHT_STAGES + TEX_BITS + 2;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] px;
        logic signed [COORD_BITS-1:0] py;
        logic [TEX_BITS-1:0]          col;
        logic [TEX_BITS-1:0]          row;
        logic [INDEX_BITS-1:0]        idx;
        logic                         degen;
    } result_t;

    function automatic logic [SIDE_BITS-1:0] eff_side(input logic [SIDE_BITS-1:0] s);
        if (s == '0) begin
            return SIDE_BITS'(1);
        end else if (s > SIDE_BITS'(MAX_TEXTURE_SIDE)) begin
            return SIDE_BITS'(MAX_TEXTURE_SIDE);
        end
        return s;
    endfunction

    logic [SIDE_BITS-1:0] cols_reg, rows_reg, cols_eff, rows_eff;
    logic [TEX_BITS-1:0]  cols_lim, rows_lim;
    logic [SIDE_BITS-1:0] cols_m1, rows_m1;

    logic signed [COORD_BITS-1:0]   vx_reg [NUM_SLOTS];
    logic signed [COORD_BITS-1:0]   vy_reg [NUM_SLOTS];
    logic        [W_BITS-1:0]       vw_reg [NUM_SLOTS];
    logic        [UV_FRAC_BITS-1:0] vu_reg [NUM_SLOTS];
    logic        [UV_FRAC_BITS-1:0] vv_reg [NUM_SLOTS];

    logic adv, accept, load_in, pixel_in;

    logic                         su_valid, su_degen;
    logic signed [COORD_BITS-1:0] su_px, su_py;
    logic signed [NW-1:0]         su_n [NUM_SLOTS];
    logic        [PB-1:0]         su_p [NUM_SLOTS];
    logic        [UW-1:0]         su_uc [NUM_SLOTS];
    logic        [UW-1:0]         su_vr [NUM_SLOTS];

    logic [SIDE_W-1:0] side_reg [LINE_DEPTH];

    logic            wt_valid, wt_kill;
    logic [NUW-1:0]  wt_num_u, wt_num_v;
    logic [DENW-1:0] wt_den;

    logic                dc_valid, dr_valid;
    logic [TEX_BITS-1:0] dc_quo, dr_quo;

    logic    z_v_reg, out_v_reg, skid_v_reg;
    result_t z_next, z_reg, out_reg, skid_reg;

    assign cols_eff = eff_side(cols_reg);
    assign rows_eff = eff_side(rows_reg);
    assign cols_m1  = cols_eff - SIDE_BITS'(1);
    assign rows_m1  = rows_eff - SIDE_BITS'(1);
    assign cols_lim = cols_m1[TEX_BITS-1:0];
    assign rows_lim = rows_m1[TEX_BITS-1:0];

    assign adv      = !skid_v_reg;
    assign s_ready  = adv;
    assign accept   = s_valid && s_ready;
    assign load_in  = accept && (s_func == FUNC_LOAD) && (s_vertex_slot < SLOT_BITS'(NUM_SLOTS));
    assign pixel_in = accept && (s_func == FUNC_PIXEL);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_reg <= SIDE_BITS'(TEX_COLS_RESET);
            rows_reg <= SIDE_BITS'(TEX_ROWS_RESET);
        end else if (cfg_wr_en) begin
            case (cfg_idx)
                REG_TEX_COLS: cols_reg <= cfg_wdata;
                REG_TEX_ROWS: rows_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (load_in) begin
            vx_reg[s_vertex_slot] <= s_pos_x;
            vy_reg[s_vertex_slot] <= s_pos_y;
            vw_reg[s_vertex_slot] <= s_depth_w;
            vu_reg[s_vertex_slot] <= s_tex_u;
            vv_reg[s_vertex_slot] <= s_tex_v;
        end
    end

    pta_setup #(
        .COORD_BITS   (COORD_BITS),
        .UV_FRAC_BITS (UV_FRAC_BITS),
        .SIDE_BITS    (SIDE_BITS)
    ) u_setup (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (pixel_in),
        .px        (s_pos_x),
        .py        (s_pos_y),
        .vx        (vx_reg),
        .vy        (vy_reg),
        .vw        (vw_reg),
        .vu        (vu_reg),
        .vv        (vv_reg),
        .cols      (cols_eff),
        .rows      (rows_eff),
        .out_valid (su_valid),
        .px_out    (su_px),
        .py_out    (su_py),
        .n_out     (su_n),
        .p_out     (su_p),
        .uc_out    (su_uc),
        .vr_out    (su_vr),
        .degen_out (su_degen)
    );

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_reg[0] <= {su_px, su_py, su_degen};
            for (int s = 1; s < LINE_DEPTH; s++) begin
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    pta_weight #(
        .COORD_BITS   (COORD_BITS),
        .UV_FRAC_BITS (UV_FRAC_BITS),
        .SIDE_BITS    (SIDE_BITS)
    ) u_weight (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (su_valid),
        .n_in      (su_n),
        .p_in      (su_p),
        .uc_in     (su_uc),
        .vr_in     (su_vr),
        .kill_in   (su_degen),
        .out_valid (wt_valid),
        .num_u     (wt_num_u),
        .num_v     (wt_num_v),
        .den       (wt_den),
        .kill_out  (wt_kill)
    );

    pta_divide #(
        .NUM_W    (NUW),
        .DEN_W    (DENW),
        .FRAC     (UV_FRAC_BITS),
        .TEX_BITS (TEX_BITS)
    ) u_div_col (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (wt_valid),
        .num       (wt_num_u),
        .den       (wt_den),
        .kill      (wt_kill),
        .lim       (cols_lim),
        .out_valid (dc_valid),
        .quo       (dc_quo)
    );

    pta_divide #(
        .NUM_W    (NUW),
        .DEN_W    (DENW),
        .FRAC     (UV_FRAC_BITS),
        .TEX_BITS (TEX_BITS)
    ) u_div_row (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (wt_valid),
        .num       (wt_num_v),
        .den       (wt_den),
        .kill      (wt_kill),
        .lim       (rows_lim),
        .out_valid (dr_valid),
        .quo       (dr_quo)
    );

    always_comb begin
        z_next.px    = side_reg[LINE_DEPTH-1][SIDE_W-1:COORD_BITS+1];
        z_next.py    = side_reg[LINE_DEPTH-1][COORD_BITS:1];
        z_next.degen = side_reg[LINE_DEPTH-1][0];
        z_next.col   = dc_quo;
        z_next.row   = dr_quo;
        z_next.idx   = INDEX_BITS'(dc_quo) + INDEX_BITS'(dr_quo) * INDEX_BITS'(cols_eff);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            z_v_reg    <= 1'b0;
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else begin
            if (adv) begin
                z_v_reg <= dc_valid && dr_valid;
            end
            if (out_v_reg && !m_ready) begin
                if (adv && z_v_reg) begin
                    skid_v_reg <= 1'b1;
                end
            end else if (skid_v_reg) begin
                out_v_reg  <= 1'b1;
                skid_v_reg <= 1'b0;
            end else begin
                out_v_reg <= z_v_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            z_reg <= z_next;
        end
        if (out_v_reg && !m_ready) begin
            if (adv) begin
                skid_reg <= z_reg;
            end
        end else if (skid_v_reg) begin
            out_reg <= skid_reg;
        end else begin
            out_reg <= z_reg;
        end
    end

    assign m_valid       = out_v_reg;
    assign m_pixel_x     = out_reg.px;
    assign m_pixel_y     = out_reg.py;
    assign m_texel_col   = out_reg.col;
    assign m_texel_row   = out_reg.row;
    assign m_texel_index = out_reg.idx;
    assign m_degenerate  = out_reg.degen;

endmodule

### tb/tb_perspective_texel_address.sv
module tb_perspective_texel_address import pta_pkg::*;;

    typedef struct {
        func_t       func;
        logic [1:0]  slot;
        logic [11:0] x;
        logic [11:0] y;
        logic [23:0] w;
        logic [15:0] u;
        logic [15:0] v;
    } stim_t;

    typedef struct packed {
        logic [11:0] x;
        logic [11:0] y;
        logic [9:0]  col;
        logic [9:0]  row;
        logic [19:0] idx;
        logic        degen;
    } texel_t;

    localparam int WATCHDOG_LIMIT = 4000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_func = FUNC_LOAD;
    logic [1:0]  s_vertex_slot = '0;
    logic [11:0] s_pos_x = '0;
    logic [11:0] s_pos_y = '0;
    logic [23:0] s_depth_w = '0;
    logic [15:0] s_tex_u = '0;
    logic [15:0] s_tex_v = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [11:0] m_pixel_x;
    logic [11:0] m_pixel_y;
    logic [9:0]  m_texel_col;
    logic [9:0]  m_texel_row;
    logic [19:0] m_texel_index;
    logic        m_degenerate;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_idx = REG_TEX_COLS;
    logic [10:0] cfg_wdata = '0;

    stim_t       pending_words[$];
    texel_t      expected_texels[$];
    stim_t       nxt;
    logic [11:0] tri_x[3];
    logic [11:0] tri_y[3];
    logic [23:0] tri_w[3];
    logic [15:0] tri_u[3];
    logic [15:0] tri_v[3];
    logic [10:0] cur_cols = 11'd64;
    logic [10:0] cur_rows = 11'd64;
    int          s_gap = 0;
    int          m_gap = 0;
    int          idle_cycles = 0;
    int          errors = 0;
    bit          quiet = 1'b0;

    perspective_texel_address DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_func(s_func),
        .s_vertex_slot(s_vertex_slot), .s_pos_x(s_pos_x), .s_pos_y(s_pos_y),
        .s_depth_w(s_depth_w), .s_tex_u(s_tex_u), .s_tex_v(s_tex_v),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_pixel_x(m_pixel_x), .m_pixel_y(m_pixel_y),
        .m_texel_col(m_texel_col), .m_texel_row(m_texel_row),
        .m_texel_index(m_texel_index), .m_degenerate(m_degenerate),
        .cfg_wr_en(cfg_wr_en), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
    );

    always #5 aclk = ~aclk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [10:0] side_of(input logic [10:0] raw);
        if (raw == 0) return 11'd1;
        if (raw > 1024) return 11'd1024;
        return raw;
    endfunction

    function automatic texel_t texel_of(input logic [11:0] px_b, input logic [11:0] py_b);
        longint signed vx[3], vy[3];
        longint signed n[3];
        longint signed px, py, area;
        logic signed [127:0] den, nu, nv, nn, pp, cs, rs;
        logic [127:0] anu, anv, aden, q;
        logic [10:0] cols, rows;
        texel_t r;
        int i;
        for (i = 0; i < 3; i++) begin
            vx[i] = 64'($signed(tri_x[i]));
            vy[i] = 64'($signed(tri_y[i]));
        end
        px = 64'($signed(px_b));
        py = 64'($signed(py_b));
        cols = side_of(cur_cols);
        rows = side_of(cur_rows);
        area = (vx[2] - vx[0]) * (vy[1] - vy[0]) - (vy[2] - vy[0]) * (vx[1] - vx[0]);
        n[0] = (vx[2] - px) * (vy[1] - py) - (vy[2] - py) * (vx[1] - px);
        n[1] = (vx[2] - vx[0]) * (py - vy[0]) - (vy[2] - vy[0]) * (px - vx[0]);
        n[2] = area - n[0] - n[1];
        r = '0;
        r.x = px_b;
        r.y = py_b;
        if (area == 0) begin
            r.degen = 1'b1;
            return r;
        end
        den = '0;
        nu = '0;
        nv = '0;
        cs = $signed(128'(cols));
        rs = $signed(128'(rows));
        for (i = 0; i < 3; i++) begin
            nn = 128'(n[i]);
            pp = $signed(128'(tri_w[(i + 1) % 3]) * 128'(tri_w[(i + 2) % 3]));
            den = den + nn * pp;
            nu = nu + nn * pp * cs * $signed({112'd0, tri_u[i]});
            nv = nv + nn * pp * rs * $signed({112'd0, tri_v[i]});
        end
        if (den == 0) return r;
        aden = (den < 0) ? -den : den;
        anu = (nu < 0) ? -nu : nu;
        anv = (nv < 0) ? -nv : nv;
        aden = aden << 16;
        q = anu / aden;
        r.col = (q > 128'(cols - 11'd1)) ? 10'(cols - 11'd1) : q[9:0];
        q = anv / aden;
        r.row = (q > 128'(rows - 11'd1)) ? 10'(rows - 11'd1) : q[9:0];
        r.idx = 20'(r.col) + 20'(r.row) * 20'(cols);
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_gap <= 0;
        end else begin
            if (s_valid && s_ready) begin
                if (s_func == FUNC_LOAD) begin
                    if (s_vertex_slot < 3) begin
                        tri_x[s_vertex_slot] = s_pos_x;
                        tri_y[s_vertex_slot] = s_pos_y;
                        tri_w[s_vertex_slot] = s_depth_w;
                        tri_u[s_vertex_slot] = s_tex_u;
                        tri_v[s_vertex_slot] = s_tex_v;
                    end
                end else begin
                    expected_texels.push_back(texel_of(s_pos_x, s_pos_y));
                end
            end
            if (!s_valid || s_ready) begin
                if (s_gap > 0) begin
                    s_gap <= s_gap - 1;
                    s_valid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    nxt = pending_words.pop_front();
                    s_valid <= 1'b1;
                    s_func <= nxt.func;
                    s_vertex_slot <= nxt.slot;
                    s_pos_x <= nxt.x;
                    s_pos_y <= nxt.y;
                    s_depth_w <= nxt.w;
                    s_tex_u <= nxt.u;
                    s_tex_v <= nxt.v;
                    s_gap <= quiet ? 0 : pick_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        texel_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_texels.size() == 0) begin
                $display("%0t: unexpected word x=%0d y=%0d", $time, m_pixel_x, m_pixel_y);
                errors++;
            end else begin
                e = expected_texels.pop_front();
                if (m_pixel_x !== e.x) begin
                    $display("%0t: pixel_x exp %0h got %0h", $time, e.x, m_pixel_x);
                    errors++;
                end
                if (m_pixel_y !== e.y) begin
                    $display("%0t: pixel_y exp %0h got %0h", $time, e.y, m_pixel_y);
                    errors++;
                end
                if (m_texel_col !== e.col) begin
                    $display("%0t: texel_col exp %0d got %0d", $time, e.col, m_texel_col);
                    errors++;
                end
                if (m_texel_row !== e.row) begin
                    $display("%0t: texel_row exp %0d got %0d", $time, e.row, m_texel_row);
                    errors++;
                end
                if (m_texel_index !== e.idx) begin
                    $display("%0t: texel_index exp %0d got %0d", $time, e.idx, m_texel_index);
                    errors++;
                end
                if (m_degenerate !== e.degen) begin
                    $display("%0t: degenerate exp %0b got %0b", $time, e.degen, m_degenerate);
                    errors++;
                end
            end
        end
        if (m_gap > 0) begin
            m_gap <= m_gap - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            m_gap <= quiet ? 0 : (($urandom_range(0, 2) == 0) ? pick_gap() : 0);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic add_load(input int slot, input int x, input int y, input int w,
                            input int u, input int v);
        stim_t t;
        t.func = FUNC_LOAD;
        t.slot = 2'(slot);
        t.x = 12'(x);
        t.y = 12'(y);
        t.w = 24'(w);
        t.u = 16'(u);
        t.v = 16'(v);
        pending_words.push_back(t);
    endtask

    task automatic add_pixel(input int x, input int y);
        stim_t t;
        t.func = FUNC_PIXEL;
        t.slot = 2'($urandom_range(0, 3));
        t.x = 12'(x);
        t.y = 12'(y);
        t.w = 24'($urandom);
        t.u = 16'($urandom);
        t.v = 16'($urandom);
        pending_words.push_back(t);
    endtask

    function automatic int clip(input int c);
        if (c < -2048) return -2048;
        if (c > 2047) return 2047;
        return c;
    endfunction

    function automatic int rand_w();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return $urandom_range(1024, 65535);
        if (r < 9) return $urandom_range(1, 24'hFFFFFF);
        return $urandom_range(1, 255);
    endfunction

    task automatic add_triangle_run(input int npix);
        int xs[3], ys[3];
        int r, cx, cy, i, lo_x, hi_x, lo_y, hi_y;
        r = $urandom_range(0, 9);
        cx = $urandom_range(0, 3600) - 1800;
        cy = $urandom_range(0, 3600) - 1800;
        for (i = 0; i < 3; i++) begin
            if (r < 7) begin
                xs[i] = clip(cx + $urandom_range(0, 80) - 40);
                ys[i] = clip(cy + $urandom_range(0, 80) - 40);
            end else begin
                xs[i] = $urandom_range(0, 4095) - 2048;
                ys[i] = $urandom_range(0, 4095) - 2048;
            end
        end
        if (r == 9) begin
            xs[2] = clip(xs[0] + 2 * (xs[1] - xs[0]));
            ys[2] = clip(ys[0] + 2 * (ys[1] - ys[0]));
        end
        for (i = 0; i < 3; i++)
            add_load(i, xs[i], ys[i], rand_w(), $urandom_range(0, 65535), $urandom_range(0, 65535));
        if ($urandom_range(0, 9) == 0)
            add_load(3, $urandom, $urandom, $urandom, $urandom, $urandom);
        lo_x = xs[0]; hi_x = xs[0]; lo_y = ys[0]; hi_y = ys[0];
        for (i = 1; i < 3; i++) begin
            if (xs[i] < lo_x) lo_x = xs[i];
            if (xs[i] > hi_x) hi_x = xs[i];
            if (ys[i] < lo_y) lo_y = ys[i];
            if (ys[i] > hi_y) hi_y = ys[i];
        end
        for (i = 0; i < npix; i++) begin
            if ($urandom_range(0, 6) == 0)
                add_pixel($urandom_range(0, 4095) - 2048, $urandom_range(0, 4095) - 2048);
            else
                add_pixel(clip(lo_x - 2 + $urandom_range(0, hi_x - lo_x + 4)),
                          clip(lo_y - 2 + $urandom_range(0, hi_y - lo_y + 4)));
        end
    endtask

    task automatic drain();
        wait (pending_words.size() == 0 && !s_valid && s_gap == 0
              && expected_texels.size() == 0);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input int val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_idx <= idx;
        cfg_wdata <= 11'(val);
        if (idx == REG_TEX_COLS) cur_cols = 11'(val);
        else cur_rows = 11'(val);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        int cols_set[7];
        int rows_set[7];
        int ph, k;
        cols_set = '{64, 1, 1024, 0, 1025, 37, 2047};
        rows_set = '{64, 1, 1024, 2047, 3, 700, 0};
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        add_load(0, -2048, -2048, 24'hFFFFFF, 0, 65535);
        add_load(1, 2047, -2048, 4096, 65535, 0);
        add_load(2, 0, 2047, 1, 32768, 32768);
        add_pixel(0, 0);
        add_pixel(-2048, -2048);
        add_pixel(2047, 2047);
        add_pixel(2047, -2048);
        add_load(3, 5, 5, 7, 7, 7);
        add_pixel(-1, 100);
        add_load(0, 0, 0, 4096, 65535, 65535);
        add_load(1, 10, 0, 4096, 65535, 65535);
        add_load(2, 0, 10, 4096, 65535, 65535);
        add_pixel(3, 3);
        add_load(2, 20, 0, 4096, 0, 0);
        add_pixel(5, 0);
        add_load(0, 0, 0, 0, 100, 200);
        add_load(1, 10, 0, 0, 300, 400);
        add_load(2, 0, 10, 0, 500, 600);
        add_pixel(2, 2);
        add_load(0, 0, 0, 0, 65535, 65535);
        add_load(1, 10, 0, 4096, 0, 0);
        add_pixel(1, 1);
        add_pixel(0, 0);
        drain();

        for (ph = 0; ph < 7; ph++) begin
            if (ph > 0) begin
                write_reg(REG_TEX_COLS, cols_set[ph]);
                write_reg(REG_TEX_ROWS, rows_set[ph]);
            end
            quiet = (ph == 2);
            for (k = 0; k < 10; k++)
                add_triangle_run($urandom_range(4, 24));
            drain();
        end
        write_reg(REG_TEX_COLS, $urandom_range(1, 1024));
        write_reg(REG_TEX_ROWS, $urandom_range(1, 1024));
        for (k = 0; k < 8; k++)
            add_triangle_run($urandom_range(4, 24));
        drain();

        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

### perspective_texel_address.f
rtl/core/pta_pkg.sv
rtl/core/pta_setup.sv
rtl/core/pta_weight.sv
rtl/core/pta_divide.sv
rtl/core/perspective_texel_address.sv
tb/tb_perspective_texel_address.sv
